>>> rtl/core/fq_pkg.sv
// ----------------------------------------------------------------------------
// fq_pkg
// Shared types, constants and helpers of the float-to-unsigned quantizer.
// ----------------------------------------------------------------------------
package fq_pkg;

    localparam int MANT_W     = 24;
    localparam int EXP_W      = 10;
    localparam int QUO_W      = 28;
    localparam int REM_W      = 25;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int T_W        = 19;
    localparam int CODE_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ZP_W       = 17;

    localparam logic [CFG_ADDR_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ZP    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDE  = 2'd2;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [16:0] TOP_WIDE    = 17'd65535;
    localparam logic [16:0] TOP_NARROW  = 17'd255;

    // MSB exponent above which the value always saturates
    localparam logic signed [EXP_W-1:0] EXP_SAT_MAX = 10'sd17;
    localparam logic signed [EXP_W-1:0] EXP_ZERO_MIN = -10'sd1;
    localparam logic signed [EXP_W-1:0] MANT_POS = 10'sd23;

    typedef enum logic [1:0] {
        KIND_NUM  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_SAT  = 2'd2,
        KIND_NAN  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     sgn;
        logic signed [EXP_W-1:0]  expo;
        logic [MANT_W-1:0]        den;
        logic [QUO_W-1:0]         quo;
        logic [REM_W-1:0]         rem;
        logic                     last;
    } div_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     sgn;
        logic [T_W-1:0]           mag;
        logic                     last;
    } rnd_t;

    function automatic logic [4:0] lzc24(input logic [MANT_W-1:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd0;
        hit = 1'b0;
        for (int i = MANT_W - 1; i >= 0; i--) begin
            if (!hit && v[i]) begin
                hit = 1'b1;
                n   = 5'(MANT_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/fq_unpack.sv
// ----------------------------------------------------------------------------
// fq_unpack
// Classifies sample and scale, normalizes both significands.
// ----------------------------------------------------------------------------
module fq_unpack (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        sample,
    input  logic               last,
    input  logic [31:0]        scale,
    output logic               out_valid,
    input  logic               out_ready,
    output fq_pkg::div_t       out_data
);
    import fq_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    logic [7:0]        xe, se;
    logic [22:0]       xf, sf;
    logic              x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
    logic [MANT_W-1:0] xm, sm;
    logic [4:0]        xlz, slz;
    logic signed [EXP_W-1:0] xexp, sexp;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xe = sample[30:23];
        se = scale[30:23];
        xf = sample[22:0];
        sf = scale[22:0];
        x_nan  = (xe == 8'hFF) && (xf != 23'd0);
        s_nan  = (se == 8'hFF) && (sf != 23'd0);
        x_inf  = (xe == 8'hFF) && (xf == 23'd0);
        s_inf  = (se == 8'hFF) && (sf == 23'd0);
        x_zero = (sample[30:0] == 31'd0);
        s_zero = (scale[30:0] == 31'd0);
        xm  = {(xe != 8'd0), xf};
        sm  = {(se != 8'd0), sf};
        xlz = lzc24(xm);
        slz = lzc24(sm);
        xexp = $signed({2'b00, (xe == 8'd0) ? 8'd1 : xe}) - $signed({5'd0, xlz});
        sexp = $signed({2'b00, (se == 8'd0) ? 8'd1 : se}) - $signed({5'd0, slz});

        data_next.sgn  = sample[31] ^ scale[31];
        data_next.expo = xexp - sexp;
        data_next.den  = sm << slz;
        data_next.quo  = '0;
        data_next.rem  = {1'b0, xm << xlz};
        data_next.last = last;
        priority if (x_nan || s_nan) begin
            data_next.kind = KIND_NAN;
        end else if (s_zero) begin
            data_next.kind = x_zero ? KIND_NAN : KIND_SAT;
        end else if (s_inf) begin
            data_next.kind = x_inf ? KIND_NAN : KIND_ZERO;
        end else if (x_inf) begin
            data_next.kind = KIND_SAT;
        end else if (x_zero) begin
            data_next.kind = KIND_ZERO;
        end else begin
            data_next.kind = KIND_NUM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/fq_div_step.sv
// ----------------------------------------------------------------------------
// fq_div_step
// One pipeline stage of the restoring significand divider.
// ----------------------------------------------------------------------------
module fq_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  fq_pkg::div_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fq_pkg::div_t  out_data
);
    import fq_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [REM_W-1:0] r;
        logic [QUO_W-1:0] q;
        logic             ge;
        data_next = in_data;
        r = in_data.rem;
        q = in_data.quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            ge = (r >= {1'b0, in_data.den});
            if (ge) begin
                r = r - {1'b0, in_data.den};
            end
            q = {q[QUO_W-2:0], ge};
            r = {r[REM_W-2:0], 1'b0};
        end
        data_next.rem = r;
        data_next.quo = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/fq_round.sv
// ----------------------------------------------------------------------------
// fq_round
// Rounds the quotient to fp32 (nearest even), then to an integer with
// halves away from zero. Two register stages.
// ----------------------------------------------------------------------------
module fq_round (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  fq_pkg::div_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fq_pkg::rnd_t  out_data
);
    import fq_pkg::*;

    // stage A: fp32 quotient
    logic                    a_valid_reg;
    kind_t                   a_kind_reg, a_kind_next;
    logic                    a_sgn_reg;
    logic                    a_last_reg;
    logic [MANT_W-1:0]       a_mant_reg, a_mant_next;
    logic signed [EXP_W-1:0] a_exp_reg, a_exp_next;
    logic                    a_ready;

    // stage B: integer
    logic                    b_valid_reg;
    rnd_t                    b_data_reg, b_data_next;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb begin
        logic [MANT_W-1:0] m;
        logic              g, st, up;
        logic [MANT_W:0]   m2;
        logic signed [EXP_W-1:0] e;
        if (in_data.quo[QUO_W-1]) begin
            m  = in_data.quo[QUO_W-1 -: MANT_W];
            g  = in_data.quo[3];
            st = (in_data.quo[2:0] != 3'd0) || (in_data.rem != '0);
            e  = in_data.expo;
        end else begin
            m  = in_data.quo[QUO_W-2 -: MANT_W];
            g  = in_data.quo[2];
            st = (in_data.quo[1:0] != 2'd0) || (in_data.rem != '0);
            e  = in_data.expo - 10'sd1;
        end
        up = g && (st || m[0]);
        m2 = {1'b0, m} + {{MANT_W{1'b0}}, up};
        if (m2[MANT_W]) begin
            a_mant_next = m2[MANT_W:1];
            a_exp_next  = e + 10'sd1;
        end else begin
            a_mant_next = m2[MANT_W-1:0];
            a_exp_next  = e;
        end
        a_kind_next = in_data.kind;
    end

    always_comb begin
        logic signed [EXP_W-1:0] shf;
        logic [4:0]              sh;
        logic [MANT_W:0]         sum;
        b_data_next.sgn  = a_sgn_reg;
        b_data_next.last = a_last_reg;
        b_data_next.kind = a_kind_reg;
        b_data_next.mag  = '0;
        shf = MANT_POS - a_exp_reg;
        sh  = shf[4:0];
        sum = {1'b0, a_mant_reg} + ((MANT_W + 1)'(1) << (sh - 5'd1));
        if (a_kind_reg == KIND_NUM) begin
            priority if (a_exp_reg > EXP_SAT_MAX) begin
                b_data_next.kind = KIND_SAT;
            end else if (a_exp_reg < EXP_ZERO_MIN) begin
                b_data_next.kind = KIND_ZERO;
            end else begin
                b_data_next.mag = T_W'(sum >> sh);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (a_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
        if (in_ready && in_valid) begin
            a_kind_reg <= a_kind_next;
            a_sgn_reg  <= in_data.sgn;
            a_last_reg <= in_data.last;
            a_mant_reg <= a_mant_next;
            a_exp_reg  <= a_exp_next;
        end
        if (a_ready && a_valid_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

>>> rtl/core/fq_clamp.sv
// ----------------------------------------------------------------------------
// fq_clamp
// Applies sign and zero point, clamps to the selected range. Output register.
// ----------------------------------------------------------------------------
module fq_clamp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fq_pkg::rnd_t                      in_data,
    input  logic signed [fq_pkg::ZP_W-1:0]    zero_point,
    input  logic                              wide_mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fq_pkg::CODE_W-1:0]         out_code,
    output logic                              out_last
);
    import fq_pkg::*;

    logic              valid_reg;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              last_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [16:0]        top;
        logic signed [21:0] v;
        logic signed [21:0] d;
        top = wide_mode ? TOP_WIDE : TOP_NARROW;
        v   = $signed({3'b000, in_data.mag});
        if (in_data.sgn) begin
            v = -v;
        end
        if (in_data.kind == KIND_ZERO) begin
            v = '0;
        end
        d = v - 22'(zero_point);
        unique case (in_data.kind)
            KIND_NAN: code_next = '0;
            KIND_SAT: code_next = in_data.sgn ? '0 : top[CODE_W-1:0];
            default: begin
                priority if (d < 22'sd0) begin
                    code_next = '0;
                end else if (d > $signed({5'd0, top})) begin
                    code_next = top[CODE_W-1:0];
                end else begin
                    code_next = d[CODE_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            code_reg <= code_next;
            last_reg <= in_data.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/core/float_to_unsigned_quantizer.sv
// ----------------------------------------------------------------------------
// float_to_unsigned_quantizer
// fp32 to unsigned 8/16-bit affine quantizer, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata = sample_bits, s_tlast = tensor_end
//  m_axis    out  m_tvalid/m_tready    m_tdata = code, m_tlast = tensor_end_out
//  cfg       in   cfg_valid/cfg_ready  cfg_addr = register index, cfg_data
//
//  One transaction per cycle sustained while m_tready stays high. Stages:
//  unpack, seven divider stages of four quotient bits each, two rounding
//  stages, clamp. Synchronous active-low reset empties the pipeline and
//  loads register defaults. Each stage holds while the next is full and
//  stalled, so a stall on m_tready backs up stage by stage without loss.
// ----------------------------------------------------------------------------
module float_to_unsigned_quantizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] sample_bits
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fq_pkg::CODE_W-1:0]         m_tdata,   // [15:0] code
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fq_pkg::*;

    logic [31:0]              scale_reg;
    logic signed [ZP_W-1:0]   zp_reg;
    logic                     wide_reg;

    div_t  d_data  [DIV_STAGES+1];
    logic  d_valid [DIV_STAGES+1];
    logic  d_ready [DIV_STAGES+1];

    logic  r_valid, r_ready;
    rnd_t  r_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            zp_reg    <= '0;
            wide_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_SCALE: scale_reg <= cfg_data;
                REG_ZP:    zp_reg    <= cfg_data[ZP_W-1:0];
                REG_WIDE:  wide_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    fq_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata),
        .last      (s_tlast),
        .scale     (scale_reg),
        .out_valid (d_valid[0]),
        .out_ready (d_ready[0]),
        .out_data  (d_data[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        fq_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (d_valid[i]),
            .in_ready  (d_ready[i]),
            .in_data   (d_data[i]),
            .out_valid (d_valid[i+1]),
            .out_ready (d_ready[i+1]),
            .out_data  (d_data[i+1])
        );
    end

    fq_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid[DIV_STAGES]),
        .in_ready  (d_ready[DIV_STAGES]),
        .in_data   (d_data[DIV_STAGES]),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    fq_clamp u_clamp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (r_valid),
        .in_ready   (r_ready),
        .in_data    (r_data),
        .zero_point (zp_reg),
        .wide_mode  (wide_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_code   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

>>> rtl/core/fq_checker.sv
// ----------------------------------------------------------------------------
// fq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module fq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

endmodule

bind float_to_unsigned_quantizer fq_checker u_fq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/float_to_unsigned_quantizer_test.sv
// ----------------------------------------------------------------------------
// float_to_unsigned_quantizer_test
// Streams fp32 samples through the quantizer under several scale, zero-point
// and width settings, with random gaps on both sides and one long output
// stall. Every code is predicted with exact integer arithmetic (IEEE divide
// with round-to-nearest-even, then half-away rounding, offset and clamp) and
// compared in order with what the block returns.
// ----------------------------------------------------------------------------
module float_to_unsigned_quantizer_test;
    import fq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int  LATENCY   = 11;
    localparam int  QUOT_SAT  = 1 << 20;
    localparam int  MAX_PRINT = 60;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last;
    } code_item_t;

    class quant_scoreboard;
        logic [31:0] scale;
        int          zp;
        logic        wide;
        code_item_t  pending_codes[$];

        function new();
            scale = SCALE_RESET;
            zp    = 0;
            wide  = 1'b1;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
            case (addr)
                REG_SCALE: scale = data;
                REG_ZP:    zp    = int'($signed(data[ZP_W-1:0]));
                REG_WIDE:  wide  = data[0];
                default: ;
            endcase
        endfunction

        static function bit is_nan(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] != 0;
        endfunction

        static function bit is_inf(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] == 0;
        endfunction

        static function bit is_zero(logic [31:0] b);
            return b[30:0] == 0;
        endfunction

        // normalized significand in [2^23, 2^24) and its power-of-two weight
        static function void unpack(input logic [31:0] b, output longint m, output int e);
            if (b[30:23] == 0) begin
                m = b[22:0];
                e = -149;
            end else begin
                m = {1'b1, b[22:0]};
                e = int'(b[30:23]) - 150;
            end
            while (m[23] == 0) begin
                m = m << 1;
                e = e - 1;
            end
        endfunction

        // rounded magnitude of |x / s|, both finite and nonzero, capped at 2^20
        static function longint quotient_mag(logic [31:0] x, logic [31:0] s);
            longint mx, ms, q, r, m, mag;
            int     ex, es, sh, e;
            bit     guard, sticky;
            unpack(x, mx, ex);
            unpack(s, ms, es);
            q      = (mx << 26) / ms;
            r      = (mx << 26) % ms;
            sh     = q[26] ? 3 : 2;
            m      = q >> sh;
            guard  = q[sh-1];
            sticky = ((q & ((64'd1 << (sh - 1)) - 1)) != 0) || r != 0;
            if (guard && (sticky || m[0]))
                m = m + 1;
            e = ex - es - 26 + sh;
            if (e + 23 > 20)
                mag = QUOT_SAT;
            else if (e + 23 < -2)
                mag = 0;
            else
                mag = (m + (64'd1 << (-e - 1))) >> (-e);
            if (mag > QUOT_SAT)
                mag = QUOT_SAT;
            return mag;
        endfunction

        function logic [CODE_W-1:0] quantize(logic [31:0] x);
            int     top;
            bit     neg;
            longint mag, v;
            top = wide ? 65535 : 255;
            neg = x[31] ^ scale[31];
            if (is_nan(x) || is_nan(scale))
                return 0;
            if (is_zero(scale))
                return is_zero(x) ? 0 : (neg ? 0 : CODE_W'(top));
            if (is_inf(x) && is_inf(scale))
                return 0;
            if (is_inf(x))
                mag = QUOT_SAT;
            else if (is_inf(scale) || is_zero(x))
                mag = 0;
            else
                mag = quotient_mag(x, scale);
            v = (neg ? -mag : mag) - zp;
            if (v < 0)
                v = 0;
            if (v > top)
                v = top;
            return CODE_W'(v);
        endfunction

        function void note_sample(logic [31:0] x, logic last);
            code_item_t c;
            c.code = quantize(x);
            c.last = last;
            pending_codes.push_back(c);
        endfunction

        function string check_code(logic [CODE_W-1:0] code, logic last);
            code_item_t c;
            string      msg;
            msg = "";
            if (pending_codes.size() == 0)
                return $sformatf("unexpected result code=%h last=%b", code, last);
            c = pending_codes.pop_front();
            if (code !== c.code)
                msg = {msg, $sformatf(" code got %h exp %h", code, c.code)};
            if (last !== c.last)
                msg = {msg, $sformatf(" last got %b exp %b", last, c.last)};
            return msg;
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CODE_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    quant_scoreboard sb = new();
    int  mismatches;
    int  codes_seen;
    bit  no_gaps;
    bit  rx_idle_free;

    float_to_unsigned_quantizer DUT (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINT)
            $display("%0t mismatch:%s", $realtime, msg);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(addr, data);
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [31:0] x, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(x, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_codes.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6: x[30:23] = 8'($urandom_range(118, 150));
            default: begin
                x[30:23] = 8'($urandom_range(124, 145));
                x[12:0]  = '0;
                if ($urandom_range(0, 1))
                    x[19:0] = '0;
            end
        endcase
        return x;
    endfunction

    // receiver: random stalls, one long hold while the sender keeps going
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (codes_seen == 300)
                stall = 200;
            else if (rx_idle_free)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            begin
                string msg;
                msg = sb.check_code(m_tdata, m_tlast);
                if (msg != "")
                    report(msg);
            end
            codes_seen++;
        end
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [31:0] directed[$] = '{
            32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4020_0000,
            32'hC020_0000, 32'h3F00_0000, 32'hBF00_0000, 32'h3FBF_FFFF,
            32'h477F_FF00, 32'h4780_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
            32'h0000_0001, 32'h8000_0001, 32'h4980_0000, 32'h4A00_0000,
            32'h3EFF_FFFF, 32'h437F_8000, 32'hC37F_8000, 32'h7F80_0001
        };
        logic [31:0] scales[$] = '{
            32'h3F80_0000, 32'h0000_0000, 32'h4380_0000, 32'h3DCC_CCCD,
            32'hBB80_0000, 32'h7F80_0000, 32'h8000_0000, 32'h0000_0001,
            32'h7FC0_0000, 32'h7F7F_FFFF, 32'h3F00_0000, 32'hFFFF_FFFF
        };
        int zps[$] = '{0, -65536, 65535, -128, 100, -1, 0, -32768, 5, 0, 1, 0};
        int count;

        mismatches   = 0;
        codes_seen   = 0;
        no_gaps      = 1'b0;
        rx_idle_free = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= REG_SCALE;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_sample(directed[i], i[0]);
        drain();

        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        foreach (scales[p]) begin
            write_reg(REG_SCALE, scales[p]);
            write_reg(REG_ZP, 32'(zps[p]));
            write_reg(REG_WIDE, 32'(p % 2));
            no_gaps      = (p % 4 == 1);
            rx_idle_free = (p % 4 == 2);
            count = (p == 0) ? 200 : 70;
            for (int i = 0; i < count; i++)
                send_sample(random_sample(), 1'($urandom_range(0, 1)));
            // a few directed samples under every setting
            for (int i = 0; i < 8; i++)
                send_sample(directed[$urandom_range(0, directed.size() - 1)], 1'b1);
            drain();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
